### sv/esmf_pkg.sv
// Package for the encoder speed median filter: field widths, limits, gain constant
// and the status struct shared between the window unit and the top level.
// No dependencies.
package esmf_pkg;

    // Fixed field widths
    localparam int TOP_W     = 16;
    localparam int DELTA_W   = 18;
    localparam int SPEED_W   = 23;
    localparam int GAIN_W    = 15;
    localparam int PROD_W    = DELTA_W + GAIN_W;
    localparam int M_TDATA_W = ((SPEED_W + DELTA_W + 7) / 8) * 8;

    // Saturation limits
    localparam int DELTA_MAX = 131071;
    localparam int DELTA_MIN = -131072;
    localparam int SPEED_MAX = 4194303;
    localparam int SPEED_MIN = -4194304;

    // 0.12923 in Q16, applied with a negative sign
    localparam logic signed [GAIN_W-1:0] SPEED_GAIN = 15'sd8469;

    localparam logic [TOP_W-1:0] TOP_RESET = 16'hFFFF;

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [SPEED_W-1:0] speed_t;

    // Window unit status toward the top level
    typedef struct packed {
        logic ready;      // idle, clearing pass finished
        logic med_valid;  // one-cycle pulse, median is valid
    } win_stat_t;

endpackage

### sv/encoder_speed_median_filter_core.sv
// Encoder speed median filter, top level. Uses esmf_pkg, esmf_delta, esmf_window, esmf_scale.
// One item at a time: a new request is taken only once the previous result has gone into
// the output register; the rate is set by the merge pass over the sorted-window memory
// (one entry a cycle).
// Reset (aresetn low, synchronous) clears control state and counter_top to 65535, then a
// clearing pass zeroes both window memories (WINDOW_LEN entries); s_tready stays low meanwhile.
module encoder_speed_median_filter_core #(
    parameter int COUNT_BITS = 16,
    parameter int WINDOW_LEN = 11
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration: counter_top
    input  logic                                    cfg_wr_en,
    input  logic [esmf_pkg::TOP_W-1:0]              cfg_wr_data,
    // input requests
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // s_tdata, from bit 0: counter_value[COUNT_BITS], counting_down[1], zero pad
    input  logic [((COUNT_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
    // result requests
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // m_tdata, from bit 0: speed_q8[23], count_delta[18], zero pad
    output logic [esmf_pkg::M_TDATA_W-1:0]          m_tdata
);
    import esmf_pkg::*;

    localparam int PAD_W = M_TDATA_W - SPEED_W - DELTA_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DELTA = 4'b0010,
        ST_BUSY  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [TOP_W-1:0]        counter_top_reg;
    logic [COUNT_BITS-1:0]   cur_reg;
    logic                    down_reg;
    delta_t                  delta_reg;
    speed_t                  speed_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    delta_t                  delta;
    delta_t                  median;
    win_stat_t               win_stat;
    logic                    speed_valid;
    speed_t                  speed;
    logic                    in_acc, out_load, out_free;

    esmf_delta #(
        .COUNT_BITS(COUNT_BITS)
    ) u_delta (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cur    (cur_reg),
        .down   (down_reg),
        .top    (counter_top_reg),
        .commit (state_reg == ST_DELTA),
        .delta  (delta)
    );

    esmf_window #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_window (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (state_reg == ST_DELTA),
        .delta  (delta),
        .stat   (win_stat),
        .median (median)
    );

    esmf_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .med_valid  (win_stat.med_valid),
        .median     (median),
        .speed_valid(speed_valid),
        .speed      (speed)
    );

    assign s_tready = (state_reg == ST_IDLE) && win_stat.ready;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    // Item sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA: begin
                state_next = ST_BUSY;
            end
            ST_BUSY: begin
                if (speed_valid) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            counter_top_reg <= TOP_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                counter_top_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cur_reg  <= s_tdata[COUNT_BITS-1:0];
            down_reg <= s_tdata[COUNT_BITS];
        end
        if (state_reg == ST_DELTA) begin
            delta_reg <= delta;
        end
        if ((state_reg == ST_BUSY) && speed_valid) begin
            speed_reg <= speed;
        end
        if (out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, delta_reg, speed_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### sv/esmf_delta.sv
// Count delta unit: holds the previous counter sample and the first-sample flag,
// and forms the saturated signed delta with wrap at counter_top+1. Uses esmf_pkg.
module esmf_delta #(
    parameter int COUNT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [COUNT_BITS-1:0]       cur,
    input  logic                        down,
    input  logic [esmf_pkg::TOP_W-1:0]  top,
    input  logic                        commit,
    output esmf_pkg::delta_t            delta
);
    import esmf_pkg::*;

    localparam int WB = ((COUNT_BITS > TOP_W) ? COUNT_BITS : (TOP_W + 1)) + 2;
    localparam logic signed [WB-1:0] HI = WB'(DELTA_MAX);
    localparam logic signed [WB-1:0] LO = WB'(DELTA_MIN);

    logic [COUNT_BITS-1:0] prev_count_reg;
    logic                  primed_reg;

    logic signed [WB-1:0] c_s, p_s, per_s, diff, raw;

    // Delta rule with wrap handling
    always_comb begin
        c_s   = $signed(WB'(cur));
        p_s   = $signed(WB'(prev_count_reg));
        per_s = $signed(WB'({1'b0, top}) + WB'(1));
        diff  = c_s - p_s;
        if (!primed_reg || (cur == prev_count_reg)) begin
            raw = '0;
        end else if (cur > prev_count_reg) begin
            raw = down ? (diff - per_s) : diff;
        end else begin
            raw = down ? diff : (diff + per_s);
        end
        if (raw > HI) begin
            delta = delta_t'(HI);
        end else if (raw < LO) begin
            delta = delta_t'(LO);
        end else begin
            delta = delta_t'(raw);
        end
    end

    // Sample history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg <= '0;
            primed_reg     <= 1'b0;
        end else if (commit) begin
            prev_count_reg <= cur;
            primed_reg     <= 1'b1;
        end
    end

endmodule

### sv/esmf_window.sv
// Delta window: a ring memory of recent deltas and a sorted copy in a second memory.
// Each new delta replaces the oldest in one merge pass; the middle entry is the median.
// Uses esmf_pkg.
module esmf_window #(
    parameter int WINDOW_LEN = 11
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  esmf_pkg::delta_t    delta,
    output esmf_pkg::win_stat_t stat,
    output esmf_pkg::delta_t    median
);
    import esmf_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_LEN);
    localparam logic [IDX_W-1:0] LAST    = IDX_W'(WINDOW_LEN - 1);
    localparam logic [IDX_W-1:0] MID_IDX = IDX_W'(WINDOW_LEN / 2);
    localparam logic [IDX_W:0]   LEN_X   = (IDX_W + 1)'(WINDOW_LEN);

    typedef enum logic [4:0] {
        W_CLEAR = 5'b00001,
        W_IDLE  = 5'b00010,
        W_OLD   = 5'b00100,
        W_PREP  = 5'b01000,
        W_MERGE = 5'b10000
    } wstate_t;

    // Memories
    delta_t ring_mem [WINDOW_LEN];
    delta_t sort_mem [WINDOW_LEN];

    wstate_t          w_state_reg, w_state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             med_valid_reg, med_valid_next;
    delta_t           d_reg, old_reg, a0_reg, a1_reg, med_reg;
    delta_t           ring_rd_reg, sort_rd_reg;

    logic             ring_we, sort_we, sort_rd_en;
    logic [IDX_W-1:0] ring_wa, sort_wa, sort_ra;
    delta_t           ring_wd, sort_wd;
    logic [IDX_W:0]   ahead;

    // Merge of one output position: drop the oldest value, insert the new one
    delta_t t_hi, t_lo, merge_r;
    logic   hi_lt_d, lo_ge_d;

    always_comb begin
        t_hi    = (a1_reg >= old_reg) ? sort_rd_reg : a1_reg;
        t_lo    = (a0_reg >= old_reg) ? a1_reg : a0_reg;
        hi_lt_d = (idx_reg != LAST) && (t_hi < d_reg);
        lo_ge_d = (idx_reg != '0) && (t_lo >= d_reg);
        if (hi_lt_d) begin
            merge_r = t_hi;
        end else if (lo_ge_d) begin
            merge_r = t_lo;
        end else begin
            merge_r = d_reg;
        end
    end

    // Sequencer and memory port control
    always_comb begin
        w_state_next   = w_state_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        med_valid_next = 1'b0;
        ring_we        = 1'b0;
        ring_wa        = slot_reg;
        ring_wd        = d_reg;
        sort_we        = 1'b0;
        sort_wa        = idx_reg;
        sort_wd        = merge_r;
        sort_rd_en     = 1'b0;
        sort_ra        = '0;
        ahead          = {1'b0, idx_reg} + (IDX_W + 1)'(2);
        case (w_state_reg)
            W_CLEAR: begin
                ring_we = 1'b1;
                ring_wa = idx_reg;
                ring_wd = '0;
                sort_we = 1'b1;
                sort_wd = '0;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST) begin
                    idx_next     = '0;
                    w_state_next = W_IDLE;
                end
            end
            W_IDLE: begin
                if (start) begin
                    w_state_next = W_OLD;
                end
            end
            W_OLD: begin
                ring_we      = 1'b1;
                sort_rd_en   = 1'b1;
                sort_ra      = '0;
                slot_next    = (slot_reg == LAST) ? '0 : slot_reg + IDX_W'(1);
                w_state_next = W_PREP;
            end
            W_PREP: begin
                sort_rd_en   = 1'b1;
                sort_ra      = IDX_W'(1);
                idx_next     = '0;
                w_state_next = W_MERGE;
            end
            W_MERGE: begin
                sort_we    = 1'b1;
                sort_rd_en = (ahead < LEN_X);
                sort_ra    = ahead[IDX_W-1:0];
                idx_next   = idx_reg + IDX_W'(1);
                if (idx_reg == LAST) begin
                    idx_next       = '0;
                    med_valid_next = 1'b1;
                    w_state_next   = W_IDLE;
                end
            end
            default: begin
                w_state_next = W_CLEAR;
                idx_next     = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_state_reg   <= W_CLEAR;
            idx_reg       <= '0;
            slot_reg      <= '0;
            med_valid_reg <= 1'b0;
        end else begin
            w_state_reg   <= w_state_next;
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            med_valid_reg <= med_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if ((w_state_reg == W_IDLE) && start) begin
            d_reg <= delta;
        end
        if (w_state_reg == W_OLD) begin
            old_reg <= ring_rd_reg;
        end
        if (w_state_reg == W_PREP) begin
            a1_reg <= sort_rd_reg;
        end
        if (w_state_reg == W_MERGE) begin
            a0_reg <= a1_reg;
            a1_reg <= sort_rd_reg;
            if (idx_reg == MID_IDX) begin
                med_reg <= merge_r;
            end
        end
    end

    // Ring memory
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_wa] <= ring_wd;
        end
        if (start) begin
            ring_rd_reg <= ring_mem[slot_reg];
        end
    end

    // Sorted memory
    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sort_mem[sort_wa] <= sort_wd;
        end
        if (sort_rd_en) begin
            sort_rd_reg <= sort_mem[sort_ra];
        end
    end

    assign stat.ready     = (w_state_reg == W_IDLE);
    assign stat.med_valid = med_valid_reg;
    assign median         = med_reg;

endmodule

### sv/esmf_scale.sv
// Speed scaling: median times -0.12923 in Q8, floor rounding, 23-bit saturation.
// Two register stages. Uses esmf_pkg.
module esmf_scale (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             med_valid,
    input  esmf_pkg::delta_t median,
    output logic             speed_valid,
    output esmf_pkg::speed_t speed
);
    import esmf_pkg::*;

    localparam int NEG_W = PROD_W + 1;
    localparam int SH_W  = NEG_W - 8;
    localparam logic signed [SH_W-1:0] HI = SH_W'(SPEED_MAX);
    localparam logic signed [SH_W-1:0] LO = SH_W'(SPEED_MIN);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic                     speed_valid_reg;
    speed_t                   speed_reg;

    logic signed [NEG_W-1:0]  neg;
    logic signed [SH_W-1:0]   shifted;
    speed_t                   speed_next;

    // Negate, floor shift by 8, saturate
    always_comb begin
        neg     = -$signed(NEG_W'(prod_reg));
        shifted = SH_W'(neg >>> 8);
        if (shifted > HI) begin
            speed_next = speed_t'(HI);
        end else if (shifted < LO) begin
            speed_next = speed_t'(LO);
        end else begin
            speed_next = speed_t'(shifted);
        end
    end

    // Valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg  <= 1'b0;
            speed_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg  <= med_valid;
            speed_valid_reg <= prod_valid_reg;
        end
    end

    // Multiply, then scale
    always_ff @(posedge aclk) begin
        if (med_valid) begin
            prod_reg <= PROD_W'(median * SPEED_GAIN);
        end
        if (prod_valid_reg) begin
            speed_reg <= speed_next;
        end
    end

    assign speed_valid = speed_valid_reg;
    assign speed       = speed_reg;

endmodule

### sv/esmf_checker.sv
// Port-level checks for encoder_speed_median_filter_core, attached by bind.
// Uses esmf_pkg for the result width.
module esmf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [esmf_pkg::M_TDATA_W-1:0] m_tdata
);
    import esmf_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // One item at a time: s_tready is checked to stay low after a request is taken
    a_busy_after_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready ##1 !s_tready))
        else $error("input ready too soon after a request");

    // A new result only appears at the end of processing, never while idle
    a_out_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without processing");

    // Clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during clearing pass");

endmodule

bind encoder_speed_median_filter_core esmf_checker u_esmf_checker (.*);

### sim/encoder_speed_median_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for encoder_speed_median_filter_core: counter samples in, speed and
// delta out, checked against an in-bench model of the delta, median window and Q8 scaling.
// Depends on esmf_pkg and the core RTL; reads no files.
module encoder_speed_median_filter_core_tb;
    import esmf_pkg::*;

    localparam int WIN_LEN       = 11;
    localparam int CLK_HALF      = 5;
    localparam int S_TDATA_W     = 24;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 188;
    localparam int SETTLE_CYCLES = 40;
    localparam int N_DIRECTED    = 24;
    localparam int SPEED_LSB     = 0;
    localparam int DELTA_LSB     = SPEED_W;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // value is the counter sample for a request row, the new counter_top for a config row
    typedef struct packed {
        row_kind_t    kind;
        logic [15:0]  value;
        logic         down;
        logic         typed;
        speed_t       speed;
        delta_t       delta;
    } stim_row_t;

    typedef struct packed {
        speed_t speed;
        delta_t delta;
    } speed_result_t;

    // DUT signals
    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [TOP_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Model state
    logic [TOP_W-1:0]       top_model   = TOP_RESET;
    logic [15:0]            last_count  = '0;
    bit                     have_sample = 1'b0;
    delta_t                 delta_ring [WIN_LEN] = '{default: '0};
    int                     ring_pos    = 0;

    speed_result_t          expected_results [$];

    // Bookkeeping
    int src_idle_pct   = 24;
    int sink_idle_pct  = 46;
    int mismatch_count = 0;
    int request_count  = 0;
    int result_count   = 0;
    int config_count   = 0;
    int nonzero_speeds = 0;
    int motion_pos     = 0;
    bit motion_down    = 1'b0;

    // Directed requests and counter_top writes; only the first few carry a hand-typed expectation
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_REQ, 16'h1234, 1'b0, 1'b1, 23'sd0, 18'sd0},    // first sample after reset
        '{ROW_REQ, 16'h1234, 1'b1, 1'b1, 23'sd0, 18'sd0},    // no movement
        '{ROW_REQ, 16'h1240, 1'b0, 1'b1, 23'sd0, 18'sd12},
        '{ROW_REQ, 16'h1230, 1'b1, 1'b1, 23'sd0, -18'sd16},
        '{ROW_REQ, 16'hFFFF, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'h0000, 1'b0, 1'b0, 23'sd0, 18'sd0},    // wrap going up
        '{ROW_REQ, 16'hFFFF, 1'b1, 1'b0, 23'sd0, 18'sd0},    // wrap going down
        '{ROW_REQ, 16'h0000, 1'b1, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'hFFFF, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'h8000, 1'b1, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'h7FFF, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'h5555, 1'b1, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'hAAAA, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'hAB00, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'hAC00, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'hAD00, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'hAE00, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_CFG, 16'd999,  1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'h2000, 1'b0, 1'b0, 23'sd0, 18'sd0},    // sample above counter_top
        '{ROW_REQ, 16'h0010, 1'b1, 1'b0, 23'sd0, 18'sd0},
        '{ROW_CFG, 16'd0,    1'b0, 1'b0, 23'sd0, 18'sd0},    // zero top, period of one
        '{ROW_REQ, 16'h0005, 1'b0, 1'b0, 23'sd0, 18'sd0},
        '{ROW_REQ, 16'h0000, 1'b1, 1'b0, 23'sd0, 18'sd0},
        '{ROW_CFG, 16'hFFFF, 1'b0, 1'b0, 23'sd0, 18'sd0}
    };

    encoder_speed_median_filter_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // counter_value[15:0], counting_down[16], zero pad
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)      // speed_q8[22:0], count_delta[40:23], zero pad
    );

    always #CLK_HALF aclk = ~aclk;

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Delta from the previous sample, push into the ring, median, scale to Q8 speed
    function automatic speed_result_t predict_speed(input logic [15:0] cv, input logic dn);
        int             c;
        int             p;
        int             per;
        int             d;
        longint         prod;
        delta_t         sorted [WIN_LEN];
        delta_t         tmp;
        speed_result_t  r;
        c   = int'(cv);
        p   = int'(last_count);
        per = int'(top_model) + 1;
        if (!have_sample) begin
            d = 0;
            have_sample = 1'b1;
        end else if (c == p) begin
            d = 0;
        end else if (c > p) begin
            d = dn ? -(p + (per - c)) : (c - p);
        end else begin
            d = dn ? (c - p) : (c + (per - p));
        end
        if (d > DELTA_MAX) d = DELTA_MAX;
        if (d < DELTA_MIN) d = DELTA_MIN;
        last_count = cv;

        delta_ring[ring_pos] = delta_t'(d);
        ring_pos = (ring_pos == WIN_LEN - 1) ? 0 : ring_pos + 1;

        sorted = delta_ring;
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            for (int j = 0; j < WIN_LEN - 1 - i; j++) begin
                if (sorted[j] > sorted[j + 1]) begin
                    tmp           = sorted[j];
                    sorted[j]     = sorted[j + 1];
                    sorted[j + 1] = tmp;
                end
            end
        end

        // floor of -(median * gain) / 256
        prod = -(longint'(sorted[WIN_LEN / 2]) * longint'(SPEED_GAIN));
        prod = prod >>> 8;
        if (prod > SPEED_MAX) prod = SPEED_MAX;
        if (prod < SPEED_MIN) prod = SPEED_MIN;
        r.speed = speed_t'(prod);
        r.delta = delta_t'(d);
        return r;
    endfunction

    // Offer one request, wait for acceptance, then record what it should produce
    task automatic send_sample(input logic [15:0] cv, input logic dn, input logic typed,
                               input speed_t typed_speed, input delta_t typed_delta);
        speed_result_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, dn, cv};
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = predict_speed(cv, dn);
        if (typed) begin
            r.speed = typed_speed;
            r.delta = typed_delta;
        end
        expected_results.push_back(r);
        request_count++;
    endtask

    // Stop sending and wait until the core has delivered everything and gone quiet
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_top(input logic [TOP_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        top_model   = v;
        config_count++;
    endtask

    // Result side backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Compare every accepted result against the oldest pending expectation
    always @(posedge aclk) begin : check_results
        speed_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                $error("result with no pending request, m_tdata=%h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[SPEED_LSB +: SPEED_W] !== want.speed) begin
                    $error("speed_q8 mismatch: expected %0d, actual %0d", want.speed,
                           $signed(m_tdata[SPEED_LSB +: SPEED_W]));
                    mismatch_count++;
                end
                if (m_tdata[DELTA_LSB +: DELTA_W] !== want.delta) begin
                    $error("count_delta mismatch: expected %0d, actual %0d", want.delta,
                           $signed(m_tdata[DELTA_LSB +: DELTA_W]));
                    mismatch_count++;
                end
                if (want.speed != 0) nonzero_speeds++;
            end
        end
    end

    // Stimulus
    initial begin
        logic [15:0]  phase_top [PHASE_COUNT];
        logic [15:0]  cv;
        logic         dn;
        int           per;
        int           step;
        int           roll;

        phase_top[0] = 16'hFFFF;
        phase_top[1] = 16'd0;
        phase_top[2] = 16'd1;
        phase_top[3] = 16'd999;
        phase_top[4] = 16'hFFFF;
        phase_top[5] = 16'($urandom_range(2, 65534));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_top(directed_rows[i].value);
            end else begin
                send_sample(directed_rows[i].value, directed_rows[i].down,
                            directed_rows[i].typed, directed_rows[i].speed,
                            directed_rows[i].delta);
            end
        end
        motion_pos = int'(last_count);

        // Random phases, one counter_top setting each
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_results();
            write_top(phase_top[ph]);
            if (ph < 2) begin
                src_idle_pct  = 24;
                sink_idle_pct = 46;
            end else if (ph < 4) begin
                src_idle_pct  = 46;
                sink_idle_pct = 24;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            per = int'(top_model) + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    // noise: any value, any direction
                    cv = 16'($urandom);
                    dn = 1'($urandom);
                end else if (roll < 20) begin
                    // standstill
                    cv = motion_pos[15:0];
                    dn = 1'($urandom);
                end else if (roll < 25) begin
                    case ($urandom_range(0, 3))
                        0: cv = 16'h0000;
                        1: cv = 16'hFFFF;
                        2: cv = top_model;
                        default: cv = top_model + 16'd1;
                    endcase
                    dn = 1'($urandom);
                end else begin
                    // realistic motion: small steps, occasional big jump, sticky direction
                    if ($urandom_range(0, 99) < 4) motion_down = ~motion_down;
                    step = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40000)
                                                        : $urandom_range(0, 300);
                    motion_pos = motion_down ? motion_pos - step : motion_pos + step;
                    motion_pos = ((motion_pos % per) + per) % per;
                    cv = motion_pos[15:0];
                    dn = motion_down;
                end
                motion_pos = int'(cv);
                send_sample(cv, dn, 1'b0, '0, '0);
            end
        end

        drain_results();
        $display("Covered %0d requests over %0d counter_top writes, %0d results compared",
                 request_count, config_count, result_count);
        $display("%0d results had a nonzero speed, %0d mismatches found",
                 nonzero_speeds, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
sv/esmf_pkg.sv
sv/esmf_delta.sv
sv/esmf_window.sv
sv/esmf_scale.sv
sv/encoder_speed_median_filter_core.sv
sv/esmf_checker.sv
sim/encoder_speed_median_filter_core_tb.sv
